// ----- hw/rtl/iso8601_to_epoch_millis_macros.svh -----
// ---------------------------------------------------------------------------
// iso8601_to_epoch_millis_macros.svh
// Assertion macros of the timestamp converter RTL.
// ---------------------------------------------------------------------------
`ifndef ISO8601_TO_EPOCH_MILLIS_MACROS_SVH
`define ISO8601_TO_EPOCH_MILLIS_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define I2E_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define I2E_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/i2e_pkg.sv -----
// ---------------------------------------------------------------------------
// i2e_pkg
// Shared types, constants and calendar tables of the timestamp converter.
// ---------------------------------------------------------------------------
`default_nettype none

package i2e_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [13:0] YEAR_MIN     = 14'd1970;
  localparam logic [13:0] ERA_YEARS    = 14'd400;
  localparam logic [22:0] ERA_DAYS     = 23'd146097;
  localparam logic [22:0] EPOCH_SHIFT  = 23'd719468;
  localparam logic [37:0] SEC_PER_DAY  = 38'd86400;
  localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN  = 17'd60;

  // One parsed string, handed from the parser to the arithmetic back end.
  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [9:0]  frac_ms;
    logic        fmt_ok;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_CAL,
    BK_DAYS,
    BK_SECS,
    BK_MS,
    BK_OUT
  } back_state_t;

  // Days in a month of a common year; zero for codes that are no month.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days from March 1 to the first of the month, months counted from March.
  function automatic logic [8:0] march_offset(input logic [3:0] mp);
    logic [8:0] ofs;
    case (mp)
      4'd0:    ofs = 9'd0;
      4'd1:    ofs = 9'd31;
      4'd2:    ofs = 9'd61;
      4'd3:    ofs = 9'd92;
      4'd4:    ofs = 9'd122;
      4'd5:    ofs = 9'd153;
      4'd6:    ofs = 9'd184;
      4'd7:    ofs = 9'd214;
      4'd8:    ofs = 9'd245;
      4'd9:    ofs = 9'd275;
      4'd10:   ofs = 9'd306;
      4'd11:   ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/i2e_if.sv -----
// ---------------------------------------------------------------------------
// i2e_if
// Valid/ready channels of the timestamp converter: text in, epoch out.
// ---------------------------------------------------------------------------
`default_nettype none

interface i2e_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface i2e_stamp_if;
  logic        valid;
  logic        ready;
  logic [47:0] epoch_millis;
  logic        well_formed;

  modport source (output valid, output epoch_millis, output well_formed, input ready);
  modport sink   (input valid, input epoch_millis, input well_formed, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/i2e_front.sv -----
// ---------------------------------------------------------------------------
// i2e_front
// Character parser: checks the layout and accumulates the numeric fields.
// ---------------------------------------------------------------------------
`default_nettype none

module i2e_front (
  input  wire logic        clk,
  input  wire logic        rst,
  i2e_text_if.sink         text,
  input  wire logic        q_full,
  output logic             push,
  output i2e_pkg::job_t    job
);

  localparam logic [4:0] POS_YM_SEP = 5'd4;
  localparam logic [4:0] POS_MD_SEP = 5'd7;
  localparam logic [4:0] POS_DT_SEP = 5'd10;
  localparam logic [4:0] POS_HM_SEP = 5'd13;
  localparam logic [4:0] POS_MS_SEP = 5'd16;
  localparam logic [4:0] POS_DOT    = 5'd19;
  localparam logic [4:0] POS_FRAC   = 5'd20;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  logic [4:0]  pos,      pos_next;
  logic [13:0] year,     year_next;
  logic [6:0]  month,    month_next;
  logic [6:0]  day,      day_next;
  logic [6:0]  hour,     hour_next;
  logic [6:0]  minute,   minute_next;
  logic [6:0]  second,   second_next;
  logic [9:0]  frac,     frac_next;
  logic [1:0]  frac_cnt, frac_cnt_next;
  logic        in_frac,  in_frac_next;
  logic        bad,      bad_next;

  logic       accept;
  logic [7:0] c;
  logic       is_dig;
  logic [3:0] dig;

  assign text.ready = !q_full;
  assign accept     = text.valid && text.ready;
  assign c          = text.text_byte;
  assign is_dig     = (c >= CH_0) && (c <= CH_9);
  assign dig        = c[3:0];

  always_comb begin
    pos_next      = pos;
    year_next     = year;
    month_next    = month;
    day_next      = day;
    hour_next     = hour;
    minute_next   = minute;
    second_next   = second;
    frac_next     = frac;
    frac_cnt_next = frac_cnt;
    in_frac_next  = in_frac;
    bad_next      = bad;

    if (pos < POS_DOT) begin
      case (pos)
        POS_YM_SEP, POS_MD_SEP: begin
          if (c != CH_DASH) bad_next = 1'b1;
        end
        POS_DT_SEP: begin
          if (c != CH_T) bad_next = 1'b1;
        end
        POS_HM_SEP, POS_MS_SEP: begin
          if (c != CH_COLON) bad_next = 1'b1;
        end
        default: begin
          if (!is_dig) begin
            bad_next = 1'b1;
          end else if (pos < POS_YM_SEP) begin
            year_next = 14'(year * 14'd10 + 14'(dig));
          end else if (pos < POS_MD_SEP) begin
            month_next = 7'(month * 7'd10 + 7'(dig));
          end else if (pos < POS_DT_SEP) begin
            day_next = 7'(day * 7'd10 + 7'(dig));
          end else if (pos < POS_HM_SEP) begin
            hour_next = 7'(hour * 7'd10 + 7'(dig));
          end else if (pos < POS_MS_SEP) begin
            minute_next = 7'(minute * 7'd10 + 7'(dig));
          end else begin
            second_next = 7'(second * 7'd10 + 7'(dig));
          end
        end
      endcase
    end else if (pos == POS_DOT) begin
      if (c == CH_DOT) in_frac_next = 1'b1;
      else             bad_next     = 1'b1;
    end else if (in_frac) begin
      if (!is_dig) begin
        bad_next = 1'b1;
      end else if (frac_cnt != 2'd3) begin
        frac_next     = 10'(frac * 10'd10 + 10'(dig));
        frac_cnt_next = frac_cnt + 2'd1;
      end
    end else begin
      bad_next = 1'b1;
    end

    if (pos != POS_FRAC) pos_next = pos + 5'd1;
  end

  // Result of the string, valid on the final byte.
  always_comb begin
    job.year    = year;
    job.month   = month;
    job.day     = day;
    job.hour    = hour;
    job.minute  = minute;
    job.second  = second;
    job.fmt_ok  = !bad && (c == CH_Z) &&
                  (((pos == POS_DOT) && !in_frac) ||
                   ((pos == POS_FRAC) && in_frac && (frac_cnt != 2'd0)));
    if (pos != POS_FRAC) begin
      job.frac_ms = 10'd0;
    end else begin
      case (frac_cnt)
        2'd1:    job.frac_ms = 10'(frac * 10'd100);
        2'd2:    job.frac_ms = 10'(frac * 10'd10);
        default: job.frac_ms = frac;
      endcase
    end
  end

  assign push = accept && text.end_of_text;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      pos      <= '0;
      year     <= '0;
      month    <= '0;
      day      <= '0;
      hour     <= '0;
      minute   <= '0;
      second   <= '0;
      frac     <= '0;
      frac_cnt <= '0;
      in_frac  <= 1'b0;
      bad      <= 1'b0;
    end else if (accept) begin
      pos      <= pos_next;
      year     <= year_next;
      month    <= month_next;
      day      <= day_next;
      hour     <= hour_next;
      minute   <= minute_next;
      second   <= second_next;
      frac     <= frac_next;
      frac_cnt <= frac_cnt_next;
      in_frac  <= in_frac_next;
      bad      <= bad_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/i2e_queue.sv -----
// ---------------------------------------------------------------------------
// i2e_queue
// Short first-in first-out queue of parsed strings between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module i2e_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire i2e_pkg::job_t  din,
  output logic                full,
  output logic                head_valid,
  output i2e_pkg::job_t       head,
  input  wire logic           pop
);

  localparam int unsigned           DEPTH = i2e_pkg::QUEUE_DEPTH;
  localparam logic [i2e_pkg::QPTR_W-1:0] LAST_SLOT = i2e_pkg::QPTR_W'(DEPTH - 1);

  i2e_pkg::job_t slots [DEPTH];

  logic [i2e_pkg::QPTR_W-1:0] wr_ptr;
  logic [i2e_pkg::QPTR_W-1:0] rd_ptr;
  logic [i2e_pkg::QCNT_W-1:0] count;
  logic                        do_push;
  logic                        do_pop;

  assign full       = (count == i2e_pkg::QCNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + i2e_pkg::QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - i2e_pkg::QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/i2e_back.sv -----
// ---------------------------------------------------------------------------
// i2e_back
// Arithmetic back end: range checks and civil-days epoch computation.
// ---------------------------------------------------------------------------
`default_nettype none

`include "iso8601_to_epoch_millis_macros.svh"

module i2e_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire i2e_pkg::job_t  head,
  output logic                pop,
  i2e_stamp_if.source         stamp
);

  i2e_pkg::back_state_t state, state_next;

  i2e_pkg::job_t cur;
  logic [13:0]   rem;
  logic [4:0]    era;
  logic [4:0]    era_adj;
  logic [17:0]   doe;
  logic [16:0]   tod;
  logic          ok;
  logic [21:0]   days;
  logic [37:0]   secs;
  logic [47:0]   epoch;
  logic          wf;

  // Calendar step signals.
  logic [8:0]  y_rem;
  logic        leap;
  logic        jan_feb;
  logic [8:0]  yoe;
  logic [4:0]  era_cal;
  logic [1:0]  yoe_cent;
  logic [3:0]  mp;
  logic [17:0] doy;
  logic [17:0] doe_cal;
  logic [4:0]  mdays;
  logic        ok_cal;
  logic [16:0] tod_cal;
  logic [47:0] ms_cal;

  always_ff @(posedge clk) begin
    if (rst) state <= i2e_pkg::BK_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      i2e_pkg::BK_IDLE: begin
        if (head_valid) begin
          pop        = 1'b1;
          state_next = i2e_pkg::BK_DIV;
        end
      end
      i2e_pkg::BK_DIV: begin
        if (rem < i2e_pkg::ERA_YEARS) state_next = i2e_pkg::BK_CAL;
      end
      i2e_pkg::BK_CAL:  state_next = i2e_pkg::BK_DAYS;
      i2e_pkg::BK_DAYS: state_next = i2e_pkg::BK_SECS;
      i2e_pkg::BK_SECS: state_next = i2e_pkg::BK_MS;
      i2e_pkg::BK_MS:   state_next = i2e_pkg::BK_OUT;
      i2e_pkg::BK_OUT: begin
        if (stamp.ready) state_next = i2e_pkg::BK_IDLE;
      end
      default: state_next = i2e_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    y_rem   = rem[8:0];
    leap    = (y_rem[1:0] == 2'b00) && (y_rem != 9'd100) && (y_rem != 9'd200) &&
              (y_rem != 9'd300);
    jan_feb = (cur.month <= 7'd2);
    era_cal = era;
    yoe     = y_rem;
    if (jan_feb) begin
      if (y_rem == 9'd0) begin
        yoe     = 9'd399;
        era_cal = era - 5'd1;
      end else begin
        yoe = y_rem - 9'd1;
      end
    end
    if (yoe >= 9'd300)      yoe_cent = 2'd3;
    else if (yoe >= 9'd200) yoe_cent = 2'd2;
    else if (yoe >= 9'd100) yoe_cent = 2'd1;
    else                    yoe_cent = 2'd0;

    mp      = jan_feb ? 4'(cur.month + 7'd9) : 4'(cur.month - 7'd3);
    doy     = 18'(i2e_pkg::march_offset(mp)) + 18'(cur.day) - 18'd1;
    doe_cal = 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(yoe_cent) + doy;

    mdays   = ((cur.month == 7'd2) && leap) ? 5'd29 : i2e_pkg::month_len(cur.month[3:0]);
    ok_cal  = cur.fmt_ok && (cur.year >= i2e_pkg::YEAR_MIN) &&
              (cur.month >= 7'd1) && (cur.month <= 7'd12) &&
              (cur.day >= 7'd1) && (cur.day <= 7'(mdays)) &&
              (cur.hour <= 7'd23) && (cur.minute <= 7'd59) && (cur.second <= 7'd59);

    tod_cal = 17'(cur.hour) * i2e_pkg::SEC_PER_HOUR +
              17'(cur.minute) * i2e_pkg::SEC_PER_MIN + 17'(cur.second);

    // Times 1000 as 1024 - 16 - 8.
    ms_cal  = (48'(secs) << 10) - (48'(secs) << 4) - (48'(secs) << 3) +
              48'(cur.frac_ms);
  end

  always_ff @(posedge clk) begin
    case (state)
      i2e_pkg::BK_IDLE: begin
        cur <= head;
        rem <= head.year;
        era <= '0;
      end
      i2e_pkg::BK_DIV: begin
        if (rem >= i2e_pkg::ERA_YEARS) begin
          rem <= rem - i2e_pkg::ERA_YEARS;
          era <= era + 5'd1;
        end
      end
      i2e_pkg::BK_CAL: begin
        era_adj <= era_cal;
        doe     <= doe_cal;
        ok      <= ok_cal;
        tod     <= tod_cal;
      end
      i2e_pkg::BK_DAYS: begin
        days <= 22'(23'(era_adj) * i2e_pkg::ERA_DAYS + 23'(doe) - i2e_pkg::EPOCH_SHIFT);
      end
      i2e_pkg::BK_SECS: begin
        secs <= 38'(days) * i2e_pkg::SEC_PER_DAY + 38'(tod);
      end
      i2e_pkg::BK_MS: begin
        epoch <= ok ? ms_cal : 48'd0;
        wf    <= ok;
      end
      default: begin
      end
    endcase
  end

  assign stamp.valid        = (state == i2e_pkg::BK_OUT);
  assign stamp.epoch_millis = epoch;
  assign stamp.well_formed  = wf;

  `I2E_ASSERT_IMP(a_bad_gives_zero, clk, rst, stamp.valid && !stamp.well_formed, stamp.epoch_millis == 48'd0, "malformed result carries a nonzero epoch")
  `I2E_ASSERT_NXT(a_pop_starts_div, clk, rst, pop, state == i2e_pkg::BK_DIV, "queue pop did not start the era division")
  `I2E_ASSERT_IMP(a_era_bounded, clk, rst, state == i2e_pkg::BK_DIV, era <= 5'd24, "era count exceeds four-digit year range")

endmodule

`default_nettype wire

// ----- hw/rtl/iso8601_to_epoch_millis.sv -----
// ---------------------------------------------------------------------------
// iso8601_to_epoch_millis
// ISO 8601 UTC timestamp text to Unix epoch milliseconds.
// ---------------------------------------------------------------------------
// The block takes a timestamp text of the form YYYY-MM-DDTHH:MM:SSZ or
// YYYY-MM-DDTHH:MM:SS.fffZ (any number of fraction digits, at least one, of
// which the first three count) one byte per transfer on the text channel,
// with end_of_text set on the final byte. One result transfer on the stamp
// channel follows each final byte: the milliseconds since 1970-01-01 UTC
// with well_formed set, or zero with well_formed cleared when the layout,
// a field range, the month length (leap years included) or the lower year
// bound of 1970 is violated. The parser front end accepts one byte in every
// cycle; a final byte places the parsed fields into a two-entry queue, and
// the parser stalls only when that queue is full. The back end works on one
// string at a time: it pops the queue, divides the year by 400 with an
// iterative era subtraction, does the calendar, day, second and millisecond
// arithmetic in turn, and then holds the result in its output register
// until taken. With the shortest legal strings of 20 bytes and years from
// 5600 on the back end is slower than the byte stream and the queue fills.
// There are no configuration registers, and reset is synchronous.
// ---------------------------------------------------------------------------
`default_nettype none

module iso8601_to_epoch_millis (
  input  wire logic    clk,
  input  wire logic    rst,
  i2e_text_if.sink     text,
  i2e_stamp_if.source  stamp
);

  // Parsed strings travel from the parser into the queue on push.
  logic          push;
  i2e_pkg::job_t front_job;

  // Queue head toward the arithmetic back end.
  logic          q_full;
  logic          head_valid;
  i2e_pkg::job_t head_job;
  logic          pop;

  // Parser: classifies every character and accumulates the fields.
  i2e_front u_front (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .q_full (q_full),
    .push   (push),
    .job    (front_job)
  );

  // Two-entry queue so the parser keeps taking bytes while the back end
  // is busy with the previous string.
  i2e_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .din        (front_job),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head_job),
    .pop        (pop)
  );

  // Back end: range checks, civil-days calculation and the output register.
  i2e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head_job),
    .pop        (pop),
    .stamp      (stamp)
  );

endmodule

`default_nettype wire
